// ===== hw/rtl/box_intersection_over_union_defines.svh =====
// Assertion macros used by the checker of the box overlap block.
// The clock is clk and the reset is rst_n, active low, in every user.
`ifndef BOX_INTERSECTION_OVER_UNION_DEFINES_SVH
`define BOX_INTERSECTION_OVER_UNION_DEFINES_SVH

// Property checked only while the block is out of reset.
`define BOXIOU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define BOXIOU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/boxiou_pkg.sv =====
package boxiou_pkg;

  // Control that travels with an item once its special cases are known.
  typedef struct packed {
    logic valid;
    logic degen;
  } boxiou_ctl_t;

endpackage

// ===== hw/rtl/boxiou_prep.sv =====
module boxiou_prep #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         valid_i,
  output logic                         up_ready,
  input  logic                         dn_ready,
  input  logic signed [COORD_BITS-1:0] a_left,
  input  logic signed [COORD_BITS-1:0] a_top,
  input  logic signed [COORD_BITS-1:0] a_right,
  input  logic signed [COORD_BITS-1:0] a_bottom,
  input  logic signed [COORD_BITS-1:0] b_left,
  input  logic signed [COORD_BITS-1:0] b_top,
  input  logic signed [COORD_BITS-1:0] b_right,
  input  logic signed [COORD_BITS-1:0] b_bottom,
  output logic                         valid_o,
  output logic [COORD_BITS-1:0]        amx_o,
  output logic [COORD_BITS-1:0]        amy_o,
  output logic [COORD_BITS-1:0]        bmx_o,
  output logic [COORD_BITS-1:0]        bmy_o,
  output logic [COORD_BITS-1:0]        ovx_o,
  output logic [COORD_BITS-1:0]        ovy_o,
  output logic                         aneg_o,
  output logic                         bneg_o
);

  localparam int CB = COORD_BITS;

  // Absolute value of a difference; it always fits CB bits.
  function automatic logic [CB-1:0] mag_of(input logic [CB:0] d);
    logic [CB:0] n;
    n = ~d + 1'b1;
    return d[CB] ? n[CB-1:0] : d[CB-1:0];
  endfunction

  // Overlap of one axis, clamped at zero.
  function automatic logic [CB-1:0] clamp_of(input logic [CB-1:0] lo,
                                              input logic [CB-1:0] hi);
    logic [CB:0] d;
    d = {hi[CB-1], hi} - {lo[CB-1], lo};
    return d[CB] ? '0 : d[CB-1:0];
  endfunction

  logic          v1_r, v2_r;
  logic          en1, en2;
  logic [CB:0]   adx_r, ady_r, bdx_r, bdy_r;
  logic [CB:0]   adx_nxt, ady_nxt, bdx_nxt, bdy_nxt;
  logic [CB-1:0] xlo_r, xhi_r, ylo_r, yhi_r;
  logic [CB-1:0] xlo_nxt, xhi_nxt, ylo_nxt, yhi_nxt;
  logic [CB-1:0] amx_r, amy_r, bmx_r, bmy_r, ovx_r, ovy_r;
  logic          aneg_r, bneg_r;

  assign en2      = !v2_r || dn_ready;
  assign en1      = !v1_r || en2;
  assign up_ready = en1;

  // First stage: extents of both boxes and the bounds of the common region.
  always_comb begin
    adx_nxt = {a_right[CB-1], a_right} - {a_left[CB-1], a_left};
    ady_nxt = {a_bottom[CB-1], a_bottom} - {a_top[CB-1], a_top};
    bdx_nxt = {b_right[CB-1], b_right} - {b_left[CB-1], b_left};
    bdy_nxt = {b_bottom[CB-1], b_bottom} - {b_top[CB-1], b_top};
    xlo_nxt = (a_left > b_left) ? a_left : b_left;
    ylo_nxt = (a_top > b_top) ? a_top : b_top;
    xhi_nxt = (a_right < b_right) ? a_right : b_right;
    yhi_nxt = (a_bottom < b_bottom) ? a_bottom : b_bottom;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= valid_i;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      adx_r <= adx_nxt;
      ady_r <= ady_nxt;
      bdx_r <= bdx_nxt;
      bdy_r <= bdy_nxt;
      xlo_r <= xlo_nxt;
      xhi_r <= xhi_nxt;
      ylo_r <= ylo_nxt;
      yhi_r <= yhi_nxt;
    end
    if (en2) begin
      amx_r  <= mag_of(adx_r);
      amy_r  <= mag_of(ady_r);
      bmx_r  <= mag_of(bdx_r);
      bmy_r  <= mag_of(bdy_r);
      ovx_r  <= clamp_of(xlo_r, xhi_r);
      ovy_r  <= clamp_of(ylo_r, yhi_r);
      aneg_r <= adx_r[CB] ^ ady_r[CB];
      bneg_r <= bdx_r[CB] ^ bdy_r[CB];
    end
  end

  assign valid_o = v2_r;
  assign amx_o   = amx_r;
  assign amy_o   = amy_r;
  assign bmx_o   = bmx_r;
  assign bmy_o   = bmy_r;
  assign ovx_o   = ovx_r;
  assign ovy_o   = ovy_r;
  assign aneg_o  = aneg_r;
  assign bneg_o  = bneg_r;

endmodule

// ===== hw/rtl/boxiou_area.sv =====
module boxiou_area #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         valid_i,
  output logic                         up_ready,
  input  logic                         dn_ready,
  input  logic [COORD_BITS-1:0]        amx_i,
  input  logic [COORD_BITS-1:0]        amy_i,
  input  logic [COORD_BITS-1:0]        bmx_i,
  input  logic [COORD_BITS-1:0]        bmy_i,
  input  logic [COORD_BITS-1:0]        ovx_i,
  input  logic [COORD_BITS-1:0]        ovy_i,
  input  logic                         aneg_i,
  input  logic                         bneg_i,
  output boxiou_pkg::boxiou_ctl_t      ctl_o,
  output logic [2*COORD_BITS+1:0]      rem_o,
  output logic [2*COORD_BITS:0]        div_o
);

  import boxiou_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int PW = 2 * CB;
  localparam int UW = PW + 1;
  localparam int RW = PW + 2;

  logic          v3_r;
  logic          en3, en4;
  logic [PW-1:0] amag_r, bmag_r, inter_r;
  logic          aneg_r, bneg_r;
  boxiou_ctl_t   ctl_r, ctl_nxt;
  logic [RW-1:0] rem_r, rem_nxt;
  logic [UW-1:0] div_r, div_nxt;
  logic [UW-1:0] union_sum;
  logic          area_pos;

  assign en4      = !ctl_r.valid || dn_ready;
  assign en3      = !v3_r || en4;
  assign up_ready = en3;

  // Second half: sort out the special cases and set up the divider. An item
  // that is not divided gets a zero dividend over one, so its quotient is 0.
  always_comb begin
    union_sum = {1'b0, amag_r} + {1'b0, bmag_r} - {1'b0, inter_r};
    priority if (!aneg_r && !bneg_r) area_pos = 1'b1;
    else if (aneg_r && bneg_r)       area_pos = 1'b0;
    else if (!aneg_r)                area_pos = amag_r > bmag_r;
    else                             area_pos = bmag_r > amag_r;

    ctl_nxt.valid = v3_r;
    rem_nxt       = '0;
    div_nxt       = UW'(1);
    priority if (amag_r == '0 || bmag_r == '0) begin
      ctl_nxt.degen = 1'b1;
    end else if (inter_r == '0) begin
      ctl_nxt.degen = !area_pos;
    end else begin
      ctl_nxt.degen = 1'b0;
      rem_nxt       = {2'b00, inter_r};
      div_nxt       = union_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r        <= 1'b0;
      ctl_r.valid <= 1'b0;
    end else begin
      if (en3) v3_r        <= valid_i;
      if (en4) ctl_r.valid <= ctl_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      amag_r  <= {{CB{1'b0}}, amx_i} * {{CB{1'b0}}, amy_i};
      bmag_r  <= {{CB{1'b0}}, bmx_i} * {{CB{1'b0}}, bmy_i};
      inter_r <= {{CB{1'b0}}, ovx_i} * {{CB{1'b0}}, ovy_i};
      aneg_r  <= aneg_i;
      bneg_r  <= bneg_i;
    end
    if (en4) begin
      ctl_r.degen <= ctl_nxt.degen;
      rem_r       <= rem_nxt;
      div_r       <= div_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign rem_o = rem_r;
  assign div_o = div_r;

endmodule

// ===== hw/rtl/boxiou_div_step.sv =====
module boxiou_div_step #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  boxiou_pkg::boxiou_ctl_t   ctl_i,
  output logic                      up_ready,
  input  logic                      dn_ready,
  input  logic [2*COORD_BITS+1:0]   rem_i,
  input  logic [2*COORD_BITS:0]     div_i,
  input  logic [FRAC_BITS+1:0]      quo_i,
  output boxiou_pkg::boxiou_ctl_t   ctl_o,
  output logic [2*COORD_BITS+1:0]   rem_o,
  output logic [2*COORD_BITS:0]     div_o,
  output logic [FRAC_BITS+1:0]      quo_o
);

  import boxiou_pkg::*;

  localparam int RW = 2 * COORD_BITS + 2;
  localparam int QW = FRAC_BITS + 2;

  boxiou_ctl_t   ctl_r;
  logic          en;
  logic          ge;
  logic [RW-1:0] diff;
  logic [RW-1:0] rem_r;
  logic [RW-2:0] div_r;
  logic [QW-1:0] quo_r;

  assign en       = !ctl_r.valid || dn_ready;
  assign up_ready = en;

  // One restoring step: compare, subtract, then shift for the next bit.
  always_comb begin
    ge   = rem_i >= {1'b0, div_i};
    diff = ge ? rem_i - {1'b0, div_i} : rem_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.valid <= 1'b0;
    end else if (en) begin
      ctl_r.valid <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r.degen <= ctl_i.degen;
      rem_r       <= {diff[RW-2:0], 1'b0};
      div_r       <= div_i;
      quo_r       <= {quo_i[QW-2:0], ge};
    end
  end

  assign ctl_o = ctl_r;
  assign rem_o = rem_r;
  assign div_o = div_r;
  assign quo_o = quo_r;

endmodule

// ===== hw/rtl/box_intersection_over_union.sv =====
// Channel   Handshake             Payload
// input     in_valid / in_stall   in_a_* and in_b_* box corners, signed
// result    out_valid / out_stall out_overlap_ratio (Q1.FRAC_BITS), out_degenerate
//
// One transfer per cycle on each side while neither side stalls. The stages in
// order: extents and bounds, magnitudes and overlaps, products, special
// cases, FRAC_BITS + 2 restoring division stages at one quotient bit each,
// and the output register. Reset empties every stage at once. A stall holds
// only the stages that are full back to the first gap, so the input keeps
// taking transfers while a result waits on out_stall, until the gaps fill.
module box_intersection_over_union #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_a_left,
  input  logic signed [COORD_BITS-1:0] in_a_top,
  input  logic signed [COORD_BITS-1:0] in_a_right,
  input  logic signed [COORD_BITS-1:0] in_a_bottom,
  input  logic signed [COORD_BITS-1:0] in_b_left,
  input  logic signed [COORD_BITS-1:0] in_b_top,
  input  logic signed [COORD_BITS-1:0] in_b_right,
  input  logic signed [COORD_BITS-1:0] in_b_bottom,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [FRAC_BITS:0]           out_overlap_ratio,
  output logic                         out_degenerate
);

  import boxiou_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int UW = 2 * CB + 1;
  localparam int RW = 2 * CB + 2;
  localparam int QW = FRAC_BITS + 2;
  // Number of division stages: the integer bit, FRAC_BITS fraction bits
  // and one extra bit for rounding.
  localparam int NS = FRAC_BITS + 2;
  localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;

  // Prep to area stage signals.
  logic          prep_ready, prep_valid;
  logic [CB-1:0] amx, amy, bmx, bmy, ovx, ovy;
  logic          aneg, bneg;

  // Division chain, element 0 is the area stage output.
  boxiou_ctl_t   ctl_c [NS+1];
  logic [RW-1:0] rem_c [NS+1];
  logic [UW-1:0] div_c [NS+1];
  logic [QW-1:0] quo_c [NS+1];
  logic          rdy_c [NS+1];
  logic          area_ready;

  // Output register and rounding.
  logic          out_en;
  logic          out_valid_r;
  logic [FRAC_BITS:0] ratio_r, ratio_nxt;
  logic          degen_r;
  logic [QW:0]   rnd;
  logic [QW-1:0] half;

  assign in_stall = !prep_ready;

  boxiou_prep #(
    .COORD_BITS(COORD_BITS)
  ) u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (in_valid),
    .up_ready (prep_ready),
    .dn_ready (area_ready),
    .a_left   (in_a_left),
    .a_top    (in_a_top),
    .a_right  (in_a_right),
    .a_bottom (in_a_bottom),
    .b_left   (in_b_left),
    .b_top    (in_b_top),
    .b_right  (in_b_right),
    .b_bottom (in_b_bottom),
    .valid_o  (prep_valid),
    .amx_o    (amx),
    .amy_o    (amy),
    .bmx_o    (bmx),
    .bmy_o    (bmy),
    .ovx_o    (ovx),
    .ovy_o    (ovy),
    .aneg_o   (aneg),
    .bneg_o   (bneg)
  );

  // Areas and intersection are multiplied here; the following stage decides
  // the zero-area and non-positive union cases and loads the divider.
  boxiou_area #(
    .COORD_BITS(COORD_BITS)
  ) u_area (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (prep_valid),
    .up_ready (area_ready),
    .dn_ready (rdy_c[0]),
    .amx_i    (amx),
    .amy_i    (amy),
    .bmx_i    (bmx),
    .bmy_i    (bmy),
    .ovx_i    (ovx),
    .ovy_i    (ovy),
    .aneg_i   (aneg),
    .bneg_i   (bneg),
    .ctl_o    (ctl_c[0]),
    .rem_o    (rem_c[0]),
    .div_o    (div_c[0])
  );

  // The quotient starts empty and gains one bit per stage.
  assign quo_c[0] = '0;

  for (genvar k = 0; k < NS; k++) begin : g_div
    boxiou_div_step #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS)
    ) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl_i    (ctl_c[k]),
      .up_ready (rdy_c[k]),
      .dn_ready (rdy_c[k+1]),
      .rem_i    (rem_c[k]),
      .div_i    (div_c[k]),
      .quo_i    (quo_c[k]),
      .ctl_o    (ctl_c[k+1]),
      .rem_o    (rem_c[k+1]),
      .div_o    (div_c[k+1]),
      .quo_o    (quo_c[k+1])
    );
  end

  // The output register frees itself whenever its result is taken, and the
  // last division stage may then move into it in the same cycle.
  assign out_en    = !out_valid_r || !out_stall;
  assign rdy_c[NS] = out_en;

  // The quotient carries one bit below the result; adding one and dropping
  // it rounds half up. A result above 1.0 is saturated to 1.0.
  always_comb begin
    rnd  = {1'b0, quo_c[NS]} + (QW+1)'(1);
    half = rnd[QW:1];
    if (half > ONE_Q) begin
      ratio_nxt = ONE_Q[FRAC_BITS:0];
    end else begin
      ratio_nxt = half[FRAC_BITS:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= ctl_c[NS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      ratio_r <= ratio_nxt;
      degen_r <= ctl_c[NS].degen;
    end
  end

  // The divisor is no longer needed after the last stage.
  assign out_valid         = out_valid_r;
  assign out_overlap_ratio = ratio_r;
  assign out_degenerate    = degen_r;

endmodule

// ===== hw/rtl/boxiou_checker.sv =====
`include "box_intersection_over_union_defines.svh"

module boxiou_checker #(
  parameter int FRAC_BITS = 16
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [FRAC_BITS:0] out_overlap_ratio,
  input logic               out_degenerate
);

  localparam logic [FRAC_BITS:0] RATIO_ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  // Reset leaves the pipeline empty and ready for a transfer.
  `BOXIOU_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid && !in_stall,
                        "not empty after reset")

  // The input can only back up when a result is held at the output.
  `BOXIOU_ASSERT(a_stall_source, in_stall |-> out_valid && out_stall,
                 "input stalled without output stall")

  // A held result keeps its value until it is taken.
  `BOXIOU_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid &&
                 $stable(out_overlap_ratio) && $stable(out_degenerate),
                 "stalled result changed")

  // No ratio exceeds one, and a degenerate result always carries a zero ratio.
  `BOXIOU_ASSERT(a_ratio_range, out_valid |-> out_overlap_ratio <= RATIO_ONE &&
                 (!out_degenerate || out_overlap_ratio == '0),
                 "result ratio out of range")

endmodule

bind box_intersection_over_union boxiou_checker #(
  .FRAC_BITS(FRAC_BITS)
) u_boxiou_checker (.*);
